// File: rtl/core/sff_pkg.sv
// sff_pkg: shared types, widths, reset constants and table builders
// for the stribeck friction feedforward block; no dependencies
`default_nettype none

package sff_pkg;

    // table geometry default
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // datapath widths
    localparam int MAG_W   = 17;               // |v|, up to 32768
    localparam int RECIP_W = 21;               // round(2^20 / d), up to 2^20
    localparam int RATIO_W = MAG_W + RECIP_W;  // |v| * recip
    localparam int LOG_W   = 16;
    localparam int EXP_W   = 33;               // 2^f with 32 fractional bits
    localparam int TANH_W  = 17;               // 65536 means 1
    localparam int QUO_W   = 17;               // blend, 65536 means 1
    localparam int DIV_W   = 50;               // blend divider operands
    localparam int PROD_W  = 36;               // k * log2(r)
    localparam int OUT_MAX = 4095;

    // configuration register indexes
    localparam logic [1:0] CFG_VS  = 2'd0;
    localparam logic [1:0] CFG_K   = 2'd1;
    localparam logic [1:0] CFG_EPS = 2'd2;

    localparam int VS_RST  = 184;
    localparam int K_RST   = 1600;
    localparam int EPS_RST = 123;
    localparam int RECIP_VS_RST  = ((1 << 20) + VS_RST / 2) / VS_RST;
    localparam int RECIP_EPS_RST = ((1 << 20) + EPS_RST / 2) / EPS_RST;

    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;

    typedef enum logic [1:0] {
        TBL_LOG2,
        TBL_EXP2,
        TBL_TANH
    } t_tbl_kind;

    // reciprocal unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_recip_stat;

    // item data that rides along the pipeline
    typedef struct packed {
        logic              neg;
        logic              zero;
        logic              bzero;
        logic [11:0]       ic;
        logic [11:0]       is;
        logic [TANH_W-1:0] th;
    } t_side;

    // unsigned 64-bit quotient by shift and subtract, table building only
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 2^t for t in [0,1), 32 fractional bits in and out
    function automatic logic [63:0] exp2_q32(logic [63:0] t);
        logic [63:0] s;
        logic [63:0] sum;
        logic [63:0] term;
        s    = ((t & 64'hFFFF_FFFF) * LN2_Q32) >> 32;
        sum  = ONE_Q32;
        term = ONE_Q32;
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * s) >> 32, 64'(n));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // log2(1 + idx/2^ab), 16 fractional bits, by repeated squaring
    function automatic logic [63:0] log2_entry(logic [63:0] idx, int ab);
        logic [63:0] x;
        logic [63:0] res;
        x   = (64'd1 << 30) + ((idx & ((64'd1 << ab) - 64'd1)) << (30 - ab));
        res = '0;
        for (int i = 0; i < 16; i++) begin
            x   = (x * x) >> 30;
            res = res << 1;
            if (x >= (64'd1 << 31)) begin
                res = res | 64'd1;
                x   = x >> 1;
            end
        end
        return res;
    endfunction

    // tanh(idx * 8 / 2^ab), 16 fractional bits
    function automatic logic [63:0] tanh_entry(logic [63:0] idx, int ab);
        logic [63:0] x20;
        logic [63:0] y;
        logic [63:0] yi;
        logic [63:0] yf;
        logic [63:0] z;
        x20 = (idx & ((64'd1 << ab) - 64'd1)) << (23 - ab);
        y   = (x20 * 64'd2 * LOG2E_Q32) >> 20;
        yi  = y >> 32;
        yf  = y & 64'hFFFF_FFFF;
        if (yf == 64'd0) begin
            z = ONE_Q32 >> yi;
        end else begin
            z = exp2_q32(ONE_Q32 - yf) >> (yi + 64'd1);
        end
        return udiv64(((ONE_Q32 - z) << 16) + ((ONE_Q32 + z) >> 1), ONE_Q32 + z);
    endfunction

    function automatic logic [63:0] rom_entry(t_tbl_kind kind, int idx, int ab);
        logic [63:0] v;
        case (kind)
            TBL_LOG2: v = log2_entry(64'(idx), ab);
            TBL_EXP2: v = exp2_q32(64'(idx) << (32 - ab));
            TBL_TANH: v = tanh_entry(64'(idx), ab);
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sff_rom.sv
// sff_rom: constant lookup table with registered read
// depends on sff_pkg for the entry builders
`default_nettype none

module sff_rom import sff_pkg::*; #(
    parameter int        ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int        DATA_BITS = LOG_W,
    parameter t_tbl_kind KIND      = TBL_LOG2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    output logic      [DATA_BITS-1:0] o_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] tbl [DEPTH];
    logic [DATA_BITS-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_ent
        localparam logic [DATA_BITS-1:0] VAL = DATA_BITS'(rom_entry(KIND, g, ADDR_BITS));
        assign tbl[g] = VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= tbl[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: rtl/core/sff_recip.sv
// sff_recip: bit-serial round(2^20 / d) for register writes
// depends on sff_pkg for widths and the status struct
`default_nettype none

module sff_recip import sff_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [11:0]        i_value,
    output t_recip_stat             o_stat,
    output logic      [RECIP_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(RECIP_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [RECIP_W-1:0] r_num, n_num;
    logic [RECIP_W-1:0] r_quo, n_quo;
    logic [11:0]        r_den, n_den;
    logic [11:0]        r_rem, n_rem;
    logic [12:0]        trial;
    logic               ge;
    logic [11:0]        den_c;

    always_comb begin
        den_c  = (i_value == 12'd0) ? 12'd1 : i_value;
        trial  = {r_rem, r_num[RECIP_W-1]};
        ge     = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RECIP_W);
            n_num  = (RECIP_W'(1) << 20) + RECIP_W'(den_c >> 1);
            n_den  = den_c;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = ge ? 12'(trial - {1'b0, r_den}) : trial[11:0];
            n_quo = {r_quo[RECIP_W-2:0], ge};
            n_num = r_num << 1;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/sff_bdiv.sv
// sff_bdiv: pipelined restoring divider, one quotient bit per stage
// depends on sff_pkg for operand and quotient widths
`default_nettype none

module sff_bdiv import sff_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo
);

    localparam int CMP_W = DIV_W + QUO_W;

    logic [DIV_W-1:0] r_rem [QUO_W];
    logic [DIV_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stg
        localparam int SH = QUO_W - 1 - s;
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] den_in;
        logic [QUO_W-1:0] q_in;
        logic [CMP_W-1:0] dsh;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
        end

        assign dsh = CMP_W'(den_in) << SH;
        assign ge  = CMP_W'(rem_in) >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? DIV_W'(CMP_W'(rem_in) - dsh) : rem_in;
                r_den[s] <= den_in;
                r_q[s]   <= {q_in[QUO_W-2:0], ge};
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/core/stribeck_friction_feedforward.sv
// stribeck_friction_feedforward: top level of the friction feedforward pipeline
// depends on sff_pkg, sff_rom, sff_recip and sff_bdiv
`default_nettype none

// Smooth Stribeck friction feedforward. Each request carries a joint velocity
// (signed, 12 fractional bits) and the joint's Coulomb and stiction currents;
// the block answers with I = (Ic + (Is-Ic)*b) * tanh(v/eps), saturated to
// +-4095 mA, where b = 1/(1+(|v|/vs)^k) is built from log2 and exp2 tables and
// a 17-stage divider. The datapath is a fully pipelined chain of 30 register
// stages plus an output register: one request is taken every cycle while the
// pipeline is not stalled and no reciprocal is running. A two-entry output
// buffer lets the pipeline keep running while a result waits; only a full
// buffer stalls it. Writing vs or eps starts a bit-serial reciprocal that
// holds off requests and further writes while it runs; writing k takes
// effect at once. The user must write registers only while no request is in
// flight; the block itself does not enforce this. There is no state between
// requests and no clearing pass after reset.

module stribeck_friction_feedforward import sff_pkg::*; #(
    parameter int TABLE_ADDRESS_BITS = TABLE_ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] joint_velocity, [27:16] coulomb_current, [39:28] stiction_current
    input  wire logic [39:0] s_axis_tdata,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] feedforward_current, [15:13] zero
    output logic      [15:0] m_axis_tdata,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    localparam int A      = TABLE_ADDRESS_BITS;
    localparam int GRP_N  = (RATIO_W + 7) / 8;   // byte groups for msb search
    localparam int ST_B   = 9 + QUO_W;           // blend quotient ready
    localparam int ST_MUL = ST_B + 1;            // (Is-Ic)*b
    localparam int ST_MAG = ST_B + 2;            // magnitude
    localparam int ST_PRD = ST_B + 3;            // magnitude * tanh
    localparam int NST    = ST_B + 4;            // rounded, signed result

    // ---------------------------------------------------------------- config
    t_recip_stat        rcp_stat;
    logic [RECIP_W-1:0] rcp_quo;
    logic               cfg_acc;
    logic               rcp_start;
    logic               r_tgt_eps, n_tgt_eps;
    logic [RECIP_W-1:0] r_recip_vs, r_recip_eps;
    logic [11:0]        r_k;

    assign o_cfg_ready = !rcp_stat.busy;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        rcp_start = 1'b0;
        n_tgt_eps = r_tgt_eps;
        if (cfg_acc) begin
            case (i_cfg_index)
                CFG_VS: begin
                    rcp_start = 1'b1;
                    n_tgt_eps = 1'b0;
                end
                CFG_EPS: begin
                    rcp_start = 1'b1;
                    n_tgt_eps = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_eps   <= 1'b0;
            r_k         <= 12'(K_RST);
            r_recip_vs  <= RECIP_W'(RECIP_VS_RST);
            r_recip_eps <= RECIP_W'(RECIP_EPS_RST);
        end else begin
            r_tgt_eps <= n_tgt_eps;
            if (cfg_acc && i_cfg_index == CFG_K) begin
                r_k <= i_cfg_data;
            end
            // reciprocal lands in the register selected by the write
            if (rcp_stat.done) begin
                if (r_tgt_eps) begin
                    r_recip_eps <= rcp_quo;
                end else begin
                    r_recip_vs <= rcp_quo;
                end
            end
        end
    end

    sff_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rcp_start),
        .i_value (i_cfg_data),
        .o_stat  (rcp_stat),
        .o_quo   (rcp_quo)
    );

    // ------------------------------------------------------- pipeline control
    logic        en;
    logic        acc;
    logic        r_vld [1:NST];
    t_side       r_side [1:NST];
    logic        r_out_vld, n_out_vld;
    logic        r_skid_vld, n_skid_vld;
    logic [12:0] r_out, n_out;
    logic [12:0] r_skid, n_skid;

    // pipeline moves whenever the skid entry is free
    assign en            = !r_skid_vld;
    assign s_axis_tready = en && !rcp_stat.busy;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // --------------------------------------------------- stage 1: |v|, sign
    logic [15:0]      raw_v;
    logic [MAG_W-1:0] mag_c;
    logic [MAG_W-1:0] r1_mag;

    // 16-bit negate so that -32768 gives 32768
    assign raw_v = s_axis_tdata[15:0];
    assign mag_c = raw_v[15] ? {1'b0, 16'(~raw_v + 16'd1)} : MAG_W'(raw_v);

    // ------------------------------------------ stage 2: ratios |v|/vs, |v|/eps
    logic [RATIO_W-1:0] r2_r20, r2_u20;

    // --------------------- stage 3: per-byte msb of the ratio, tanh table read
    logic [GRP_N*8-1:0] pad_c;
    logic               nz_c  [GRP_N];
    logic [2:0]         pos_c [GRP_N];
    logic               r3_nz  [GRP_N];
    logic [2:0]         r3_pos [GRP_N];
    logic [RATIO_W-1:0] r3_r20;
    logic               r3_tsat;
    logic [TANH_W-1:0]  tanh_q;

    assign pad_c = (GRP_N*8)'(r2_r20);

    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            nz_c[g]  = |pad_c[g*8 +: 8];
            pos_c[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (pad_c[g*8 + b]) begin
                    pos_c[g] = 3'(b);
                end
            end
        end
    end

    sff_rom #(
        .ADDR_BITS (A),
        .DATA_BITS (TANH_W),
        .KIND      (TBL_TANH)
    ) u_tanh (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (r2_u20[22 -: A]),
        .o_data (tanh_q)
    );

    // ------------------------------------------------ stage 4: msb position
    logic [5:0]         p_c;
    logic [5:0]         r4_p;
    logic [RATIO_W-1:0] r4_r20;
    logic [TANH_W-1:0]  th_c;

    always_comb begin
        p_c = 6'd0;
        for (int g = 0; g < GRP_N; g++) begin
            if (r3_nz[g]) begin
                p_c = {3'(g), r3_pos[g]};
            end
        end
    end

    // tanh saturates to one for u of 8 or more
    assign th_c = r3_tsat ? (TANH_W'(1) << 16) : tanh_q;

    // -------------------------------- stage 5: normalize, log2 table address
    logic [RATIO_W-1:0] norm_c;
    logic [A-1:0]       r5_idx;
    logic signed [6:0]  r5_pint;

    assign norm_c = r4_r20 << (6'(RATIO_W - 1) - r4_p);

    // ---------------------------------------------- stage 6: log2 fraction
    logic [LOG_W-1:0]  log_q;
    logic signed [6:0] r6_pint;

    sff_rom #(
        .ADDR_BITS (A),
        .DATA_BITS (LOG_W),
        .KIND      (TBL_LOG2)
    ) u_log2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (r5_idx),
        .o_data (log_q)
    );

    // ------------------------------------------------- stage 7: k * log2(r)
    logic signed [22:0]       l_c;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] r7_prod;

    assign l_c    = $signed({r6_pint, log_q});
    assign prod_c = $signed({1'b0, r_k}) * l_c;

    // ----------------------- stage 8: exp2 of the fraction, integer exponent
    logic [EXP_W-1:0]   exp_q;
    logic signed [15:0] r8_ei;

    sff_rom #(
        .ADDR_BITS (A),
        .DATA_BITS (EXP_W),
        .KIND      (TBL_EXP2)
    ) u_exp2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_addr (r7_prod[19 -: A]),
        .o_data (exp_q)
    );

    // ------------------------- stage 9: scale power, divider operands
    logic [48:0]      pw_c;
    logic [15:0]      nei_c;
    logic             big_c;
    logic [DIV_W-1:0] r9_num, r9_den;
    logic [QUO_W-1:0] b_q;

    assign big_c = r8_ei > 16'sd16;
    assign nei_c = 16'(-r8_ei);

    always_comb begin
        if (r8_ei >= 16'sd0) begin
            pw_c = 49'(exp_q) << r8_ei[4:0];
        end else if (r8_ei < -16'sd40) begin
            pw_c = '0;
        end else begin
            pw_c = 49'(exp_q) >> nei_c[5:0];
        end
    end

    // b = round(2^48 / (2^32 + P)) over the following stages
    sff_bdiv u_bdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r9_num),
        .i_den (r9_den),
        .o_quo (b_q)
    );

    // ------------------------------------------------ tail: mix and round
    logic [QUO_W-1:0]   bsel_c;
    logic signed [12:0] diff_c;
    logic signed [30:0] db_c;
    logic signed [30:0] r27_db;
    logic signed [30:0] sum_c;
    logic [27:0]        r28_mag;
    logic [44:0]        r29_prd;
    logic [45:0]        rnd_c;
    logic [13:0]        res_c;
    logic [11:0]        sat_c;
    logic [12:0]        val_c;
    logic [12:0]        r30_res;

    assign bsel_c = r_side[ST_B].bzero ? '0 : b_q;
    assign diff_c = $signed({1'b0, r_side[ST_B].is}) - $signed({1'b0, r_side[ST_B].ic});
    assign db_c   = diff_c * $signed({1'b0, bsel_c});
    assign sum_c  = $signed({3'b0, r_side[ST_MUL].ic, 16'b0}) + r27_db;
    assign rnd_c  = 46'(r29_prd) + (46'd1 << 31);
    assign res_c  = rnd_c[45:32];
    assign sat_c  = (res_c > 14'(OUT_MAX)) ? 12'(OUT_MAX) : res_c[11:0];

    always_comb begin
        if (r_side[ST_PRD].zero) begin
            val_c = '0;
        end else if (r_side[ST_PRD].neg) begin
            val_c = 13'(-{1'b0, sat_c});
        end else begin
            val_c = {1'b0, sat_c};
        end
    end

    // --------------------------------------------------- pipeline registers
    t_side side4_c;
    t_side side9_c;

    // side data entering stages 4 and 9 picks up the tanh value and the big flag
    always_comb begin
        side4_c       = r_side[3];
        side4_c.th    = th_c;
        side9_c       = r_side[8];
        side9_c.bzero = big_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= acc;
            for (int i = 2; i <= NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1].neg   <= raw_v[15];
            r_side[1].zero  <= raw_v == 16'd0;
            r_side[1].bzero <= 1'b0;
            r_side[1].ic    <= s_axis_tdata[27:16];
            r_side[1].is    <= s_axis_tdata[39:28];
            r_side[1].th    <= '0;
            for (int i = 2; i <= NST; i++) begin
                if (i == 4) begin
                    r_side[i] <= side4_c;
                end else if (i == 9) begin
                    r_side[i] <= side9_c;
                end else begin
                    r_side[i] <= r_side[i-1];
                end
            end

            r1_mag  <= mag_c;
            r2_r20  <= RATIO_W'(r1_mag) * RATIO_W'(r_recip_vs);
            r2_u20  <= RATIO_W'(r1_mag) * RATIO_W'(r_recip_eps);
            for (int g = 0; g < GRP_N; g++) begin
                r3_nz[g]  <= nz_c[g];
                r3_pos[g] <= pos_c[g];
            end
            r3_r20  <= r2_r20;
            r3_tsat <= |r2_u20[RATIO_W-1:23];
            r4_p    <= p_c;
            r4_r20  <= r3_r20;
            r5_idx  <= norm_c[RATIO_W-2 -: A];
            r5_pint <= $signed({1'b0, r4_p}) - 7'sd20;
            r6_pint <= r5_pint;
            r7_prod <= prod_c;
            r8_ei   <= r7_prod[PROD_W-1:20];
            r9_den  <= DIV_W'(pw_c) + (DIV_W'(1) << 32);
            r9_num  <= (DIV_W'(1) << 48) + (DIV_W'(1) << 31) + DIV_W'(pw_c >> 1);
            r27_db  <= db_c;
            r28_mag <= sum_c[27:0];
            r29_prd <= 45'(r28_mag) * 45'(r_side[ST_MAG].th);
            r30_res <= val_c;
        end
    end

    // ----------------------------------------- output register and skid entry
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_out_vld && m_axis_tready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (en && r_vld[NST]) begin
            if (!n_out_vld) begin
                n_out_vld = 1'b1;
                n_out     = r30_res;
            end else begin
                n_skid_vld = 1'b1;
                n_skid     = r30_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

`default_nettype wire
